FILE: rtl/core/lrc_pkg.sv
// Package for the LRU register cache: shared widths, default parameter values,
// the controller state type and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none
package lrc_pkg;

    // Fixed widths of the request and result fields.
    localparam int VAR_ID_W    = 16;
    localparam int REG_INDEX_W = 3;

    // Defaults for the top-level parameters.
    localparam int NUM_SLOTS_DEF = 8;
    localparam int ID_BITS_DEF   = 16;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_lrc_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the incoming request
        logic exec;  // look up, update the slots and register the result
    } t_lrc_cmd;

endpackage
`default_nettype wire

FILE: rtl/core/lrc_ctrl.sv
// Controller for the LRU register cache: accepts a request and sequences the
// lookup-and-update step in the datapath. Depends on lrc_pkg.
`default_nettype none
module lrc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output lrc_pkg::t_lrc_cmd      o_cmd
);
    import lrc_pkg::*;

    t_lrc_state r_state;
    t_lrc_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        busy       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = start;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                busy       = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/lrc_datapath.sv
// Datapath for the LRU register cache: slot tags, valid and dirty bits, ages,
// the parallel tag compare, victim selection and the result register.
// Depends on lrc_pkg.
`default_nettype none
module lrc_datapath #(
    parameter int NUM_SLOTS = lrc_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = lrc_pkg::ID_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lrc_pkg::t_lrc_cmd                 i_cmd,
    input  wire logic [lrc_pkg::VAR_ID_W-1:0]      i_variable_id,
    input  wire logic                              i_is_write,
    output logic                                   o_valid,
    output logic [lrc_pkg::REG_INDEX_W-1:0]        o_reg_index,
    output logic                                   o_hit,
    output logic                                   o_evicted,
    output logic                                   o_writeback,
    output logic [lrc_pkg::VAR_ID_W-1:0]           o_evicted_id
);
    import lrc_pkg::*;

    // The identifier port is VAR_ID_W bits, so no stored tag needs more.
    localparam int TAG_W  = (ID_BITS < VAR_ID_W) ? ID_BITS : VAR_ID_W;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int AGE_W  = $clog2(NUM_SLOTS);
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(NUM_SLOTS - 1);

    logic [TAG_W-1:0]  r_req_id;
    logic              r_req_wr;
    logic [NUM_SLOTS-1:0] r_slot_valid;
    logic [NUM_SLOTS-1:0] r_slot_dirty;
    logic [TAG_W-1:0]  r_slot_tag [NUM_SLOTS];
    logic [AGE_W-1:0]  r_slot_age [NUM_SLOTS];

    logic              r_valid;
    logic [REG_INDEX_W-1:0] r_reg_index;
    logic              r_hit;
    logic              r_evicted;
    logic              r_writeback;
    logic [VAR_ID_W-1:0] r_evicted_id;

    logic [NUM_SLOTS-1:0] match;
    logic [NUM_SLOTS-1:0] oldest;
    logic [NUM_SLOTS-1:0] age_inc;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] victim_idx;
    logic [SLOT_W-1:0] sel_idx;
    logic              hit;
    logic              any_free;
    logic              evict;
    logic [AGE_W-1:0]  hit_age;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match[i]  = r_slot_valid[i] && (r_slot_tag[i] == r_req_id);
            oldest[i] = (r_slot_age[i] == AGE_OLDEST);
        end
    end

    // Lowest-numbered candidate wins in each priority encoder.
    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (!r_slot_valid[i]) begin
                free_idx = SLOT_W'(i);
            end
            if (oldest[i]) begin
                victim_idx = SLOT_W'(i);
            end
        end
    end

    // With every slot valid the ages are a permutation of 0 .. NUM_SLOTS-1,
    // so the victim is the one slot at the oldest age.
    assign hit      = |match;
    assign any_free = ~&r_slot_valid;
    assign evict    = !hit && !any_free;
    assign sel_idx  = hit ? hit_idx : (any_free ? free_idx : victim_idx);
    assign hit_age  = r_slot_age[hit_idx];

    // On a hit only slots younger than the hit slot age; on a fill all valid ones do.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            age_inc[i] = (SLOT_W'(i) != sel_idx) && r_slot_valid[i]
                         && (!hit || (r_slot_age[i] < hit_age));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_id <= TAG_W'(i_variable_id);
            r_req_wr <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_slot_dirty <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_age[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (SLOT_W'(i) == sel_idx) begin
                    r_slot_valid[i] <= 1'b1;
                    r_slot_age[i]   <= '0;
                    r_slot_dirty[i] <= (hit && r_slot_dirty[i]) || r_req_wr;
                end else if (age_inc[i]) begin
                    r_slot_age[i] <= r_slot_age[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !hit) begin
            r_slot_tag[sel_idx] <= r_req_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_reg_index  <= REG_INDEX_W'(sel_idx);
            r_hit        <= hit;
            r_evicted    <= evict;
            r_writeback  <= evict && r_slot_dirty[victim_idx];
            r_evicted_id <= evict ? VAR_ID_W'(r_slot_tag[victim_idx]) : '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_reg_index  = r_reg_index;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_writeback  = r_writeback;
    assign o_evicted_id = r_evicted_id;

endmodule
`default_nettype wire

FILE: rtl/core/lru_register_cache_with_writeback.sv
// Top level of the LRU register cache with dirty writeback: joins the
// controller and the datapath. Depends on lrc_pkg, lrc_ctrl and lrc_datapath.
//
// Usage: a request (i_variable_id, i_is_write) is taken at a rising edge with
// start high and busy low. Each request yields exactly one result, shown on
// o_reg_index, o_hit, o_evicted, o_writeback and o_evicted_id for one cycle
// while o_valid is high.
// Timing: the cycle after acceptance runs the parallel tag compare over all
// slots, picks the slot (hit, lowest free, or oldest) and updates tags, dirty
// bits and ages in one step; busy is high during that cycle. The result is
// registered at the end of that cycle and shown with o_valid in the cycle
// after it. A new request is not taken while busy is high, that is while the
// lookup-and-update of the previous request runs in the controller.
// Reset (synchronous, active low) empties the cache: all slots invalid and
// clean, all ages zero, no result pending. Results cannot be held off by the
// receiver; each transaction must be taken in its strobe cycle.
`default_nettype none
module lru_register_cache_with_writeback #(
    parameter int NUM_SLOTS = lrc_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = lrc_pkg::ID_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [lrc_pkg::VAR_ID_W-1:0]      i_variable_id,
    input  wire logic                              i_is_write,
    output logic                                   o_valid,
    output logic [lrc_pkg::REG_INDEX_W-1:0]        o_reg_index,
    output logic                                   o_hit,
    output logic                                   o_evicted,
    output logic                                   o_writeback,
    output logic [lrc_pkg::VAR_ID_W-1:0]           o_evicted_id
);
    import lrc_pkg::*;

    t_lrc_cmd cmd;

    lrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    lrc_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_variable_id (i_variable_id),
        .i_is_write    (i_is_write),
        .o_valid       (o_valid),
        .o_reg_index   (o_reg_index),
        .o_hit         (o_hit),
        .o_evicted     (o_evicted),
        .o_writeback   (o_writeback),
        .o_evicted_id  (o_evicted_id)
    );

    // An accepted request is followed by the busy cycle and then its result.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 o_valid))
        else $error("accepted request not followed by busy and result");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted && !o_writeback && (o_evicted_id == '0)))
        else $error("hit reported together with an eviction");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writeback) |-> o_evicted)
        else $error("writeback without an eviction");

    a_result_only_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a lookup cycle");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for lru_register_cache_with_writeback: directed corner
// requests, then random traffic at several sender idle rates, checked against an
// in-bench LRU predictor. Depends on lrc_pkg and the cache RTL.
module tb;
    import lrc_pkg::*;

    localparam int SLOTS         = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [REG_INDEX_W-1:0] reg_index;
        logic                   hit;
        logic                   evicted;
        logic                   writeback;
        logic [VAR_ID_W-1:0]    evicted_id;
    } t_lookup;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VAR_ID_W-1:0]    i_variable_id;
    logic                   i_is_write;
    logic                   o_valid;
    logic [REG_INDEX_W-1:0] o_reg_index;
    logic                   o_hit;
    logic                   o_evicted;
    logic                   o_writeback;
    logic [VAR_ID_W-1:0]    o_evicted_id;

    // Shadow copy of the cache contents, advanced once per accepted request.
    logic                slot_held [SLOTS];
    logic [VAR_ID_W-1:0] slot_tag [SLOTS];
    logic                slot_modified [SLOTS];
    int                  slot_rank [SLOTS];

    t_lookup expected_lookups [$];
    int      mismatches;
    int      results_seen;
    int      cycle_count;
    int      sender_idle_pct;

    lru_register_cache_with_writeback dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_variable_id(i_variable_id),
        .i_is_write   (i_is_write),
        .o_valid      (o_valid),
        .o_reg_index  (o_reg_index),
        .o_hit        (o_hit),
        .o_evicted    (o_evicted),
        .o_writeback  (o_writeback),
        .o_evicted_id (o_evicted_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_lookup predict_lookup(input logic [VAR_ID_W-1:0] id, input logic wr);
        t_lookup r;
        int      slot;
        int      limit;
        bit      found;
        r     = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_held[i] && slot_tag[i] == id) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            limit = slot_rank[slot];
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && !slot_held[i]) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Full cache: the oldest slot goes, lowest index on a tie.
                slot = 0;
                for (int i = 1; i < SLOTS; i++) begin
                    if (slot_rank[i] > slot_rank[slot]) slot = i;
                end
                r.evicted    = 1'b1;
                r.writeback  = slot_modified[slot];
                r.evicted_id = slot_tag[slot];
            end
            slot_held[slot]     = 1'b1;
            slot_tag[slot]      = id;
            slot_modified[slot] = 1'b0;
            limit               = SLOTS + 1;
        end
        // Only entries younger than the touched one age on a hit; all age on a fill.
        for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_held[i] && slot_rank[i] < limit) slot_rank[i]++;
        end
        slot_rank[slot] = 0;
        if (wr) slot_modified[slot] = 1'b1;
        r.reg_index = REG_INDEX_W'(slot);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [VAR_ID_W-1:0] want,
                                 input logic [VAR_ID_W-1:0] got);
        if (got !== want) begin
            note_failure($sformatf("result %0d %s expected 0x%0h actual 0x%0h",
                                   results_seen, name, want, got));
        end
    endtask

    task automatic check_result();
        t_lookup want;
        t_lookup got;
        got = {o_reg_index, o_hit, o_evicted, o_writeback, o_evicted_id};
        if (expected_lookups.size() == 0) begin
            note_failure($sformatf("result %0d arrived with no request outstanding: %p",
                                   results_seen, got));
        end else begin
            want = expected_lookups.pop_front();
            compare_field("reg_index", VAR_ID_W'(want.reg_index), VAR_ID_W'(got.reg_index));
            compare_field("hit", VAR_ID_W'(want.hit), VAR_ID_W'(got.hit));
            compare_field("evicted", VAR_ID_W'(want.evicted), VAR_ID_W'(got.evicted));
            compare_field("writeback", VAR_ID_W'(want.writeback), VAR_ID_W'(got.writeback));
            compare_field("evicted_id", want.evicted_id, got.evicted_id);
        end
        results_seen++;
    endtask

    // Results are checked before the transaction on the same edge is predicted,
    // so the oldest expectation is always the one compared.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) check_result();
            if (start && !busy) expected_lookups.push_back(predict_lookup(i_variable_id, i_is_write));
        end
    end

    task automatic send_request(input logic [VAR_ID_W-1:0] id, input logic wr);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            start         <= 1'b0;
            i_variable_id <= VAR_ID_W'($urandom);
            i_is_write    <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_variable_id <= id;
        i_is_write    <= wr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_lookups.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Fills the cache, then walks through hits on dirty and clean entries and
    // evictions of both dirty and clean victims, using extreme identifiers.
    task automatic test_directed_corners();
        sender_idle_pct = 0;
        send_request(16'h0000, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b1);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h5555, 1'b1);
        send_request(16'h0001, 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'h1234, 1'b1);
        send_request(16'h00FF, 1'b0);
        send_request(16'h7FFF, 1'b0);
        send_request(16'hFF00, 1'b0);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h0F0F, 1'b1);
        send_request(16'hF0F0, 1'b0);
        send_request(16'h0F0F, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b1);
    endtask

    // Most identifiers come from a small working set so that hits, fills and
    // evictions all occur; the rest are fully random.
    task automatic test_random_traffic(input int count, input int idle_pct);
        logic [VAR_ID_W-1:0] working_set [16];
        int                  set_size;
        logic [VAR_ID_W-1:0] id;
        sender_idle_pct = idle_pct;
        set_size        = 1;
        for (int n = 0; n < count; n++) begin
            if (n % 70 == 0) begin
                set_size = $urandom_range(5, 16);
                for (int i = 0; i < 16; i++) working_set[i] = VAR_ID_W'($urandom);
            end
            if ($urandom_range(3) == 0) id = VAR_ID_W'($urandom);
            else id = working_set[$urandom_range(set_size - 1)];
            send_request(id, 1'($urandom));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_variable_id   <= '0;
        i_is_write      <= 1'b0;
        mismatches      = 0;
        results_seen    = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_held[i]     = 1'b0;
            slot_tag[i]      = '0;
            slot_modified[i] = 1'b0;
            slot_rank[i]     = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        wait_until_drained();
        test_random_traffic(350, 0);
        wait_until_drained();
        test_random_traffic(350, 77);
        test_random_traffic(350, 27);
        wait_until_drained();

        if (mismatches == 0 && expected_lookups.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lrc_pkg.sv
rtl/core/lrc_ctrl.sv
rtl/core/lrc_datapath.sv
rtl/core/lru_register_cache_with_writeback.sv
tb/sv/tb.sv
